// ----- sv/bnfa_pkg.sv -----
// Shared types, command codes and defaults of the bitmap next-fit allocator.
package bnfa_pkg;

  localparam int unsigned SLOTS_DEFAULT = 256;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_SET   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_QRY_RD,
    ST_SCAN,
    ST_LAST_RD,
    ST_FINISH
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_en;
    logic ld_item;
    logic rd_slot;
    logic scan_en;
    logic rd_last;
    logic wr_set;
    logic ld_res;
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic hit;
    logic miss;
  } stat_t;

endpackage

// ----- sv/bitmap_next_fit_allocator_top.sv -----
// Top level of the bitmap next-fit allocator: controller plus datapath.
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i / in_stall_o    cmd_i, slot_i, used_value_i
//   out      source     out_valid_o / out_stall_i  result_slot_o, slot_used_o, full_res_o
//
// The map lives in a byte-wide memory of (SLOTS+7)/8 words; one beat is taken at a time.
// Allocate scans one map byte per cycle through the single read port.
// Set reads and then writes its map word, query reads it, and other commands finish directly.
// After reset a clearing pass writes zero to every map word, with in_stall_o held high.
// A result waits in the output register under out_stall_i while the next beat is
// accepted; that beat finishes once the register is free.
module bitmap_next_fit_allocator_top
  import bnfa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] slot_i,
  input  logic       used_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] result_slot_o,
  output logic       slot_used_o,
  output logic       full_res_o
);

  ctl_t  ctl;
  stat_t stat;

  // Sequence the clear pass, the read-modify-write of set, and the allocate scan.
  bnfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .cmd_i       (cmd_i),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctl_o       (ctl)
  );

  // Hold the map, the last allocated slot and the result register.
  bnfa_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .slot_i        (slot_i),
    .used_value_i  (used_value_i),
    .result_slot_o (result_slot_o),
    .slot_used_o   (slot_used_o),
    .full_res_o    (full_res_o)
  );

endmodule

// ----- sv/bnfa_ctrl.sv -----
// Controller state machine of the bitmap next-fit allocator.
module bnfa_ctrl
  import bnfa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  logic       out_stall_i,
  input  stat_t      stat_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  output ctl_t       ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ctl_o.clr_en = 1'b1;
        if (stat_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.ld_item = 1'b1;
          if (cmd_i == CMD_ALLOC)      state_d = ST_SCAN;
          else if (cmd_i == CMD_SET)   state_d = ST_SET_RD;
          else if (cmd_i == CMD_QUERY) state_d = ST_QRY_RD;
          else                         state_d = ST_FINISH;
        end
      end
      ST_SET_RD: begin
        ctl_o.rd_slot = 1'b1;
        state_d       = ST_SET_WR;
      end
      ST_SET_WR: begin
        ctl_o.wr_set = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_QRY_RD: begin
        ctl_o.rd_slot = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_SCAN: begin
        ctl_o.scan_en = 1'b1;
        if (stat_i.hit)       state_d = ST_FINISH;
        else if (stat_i.miss) state_d = ST_LAST_RD;
      end
      ST_LAST_RD: begin
        ctl_o.rd_last = 1'b1;
        state_d       = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          ctl_o.ld_res = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.ld_res)      out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

endmodule

// ----- sv/bnfa_dpath.sv -----
// Datapath of the bitmap next-fit allocator: byte-wide map memory, scan and result registers.
module bnfa_dpath
  import bnfa_pkg::*;
#(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctl_t       ctl_i,
  output stat_t      stat_o,
  input  logic [1:0] cmd_i,
  input  logic [7:0] slot_i,
  input  logic       used_value_i,
  output logic [7:0] result_slot_o,
  output logic       slot_used_o,
  output logic       full_res_o
);

  localparam int unsigned WORDS   = (SLOTS + 7) / 8;
  localparam int unsigned WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IDX_W   = $clog2(SLOTS);
  localparam int unsigned IDXX    = WADDR_W + 3;
  localparam int unsigned XW      = (IDXX > 8) ? IDXX : 8;
  localparam int unsigned CNT_W   = $clog2(WORDS + 2);

  logic [7:0]         mem_q [WORDS];
  logic [7:0]         rdata_q;

  logic [1:0]         cmd_q;
  logic [7:0]         slot_q;
  logic               val_q;
  logic [IDX_W-1:0]   last_q;
  logic               full_q;
  logic [WADDR_W-1:0] clr_cnt_q;
  logic [WADDR_W-1:0] scan_ptr_q;
  logic [CNT_W-1:0]   issue_cnt_q;
  logic [2:0]         sbit_q;
  logic               pend_q;
  logic               rfirst_q;
  logic               rfinal_q;
  logic [WADDR_W-1:0] rword_q;

  logic [7:0]         res_slot_q;
  logic               res_used_q;
  logic               res_full_q;

  logic [IDX_W-1:0]   start;
  logic [IDXX-1:0]    start_x;
  logic [XW-1:0]      slot_x;
  logic [XW-1:0]      last_x;
  logic               in_range;
  logic               issuing;
  logic [7:0]         free_bits;
  logic [2:0]         hit_b;
  logic               hit;
  logic [IDXX-1:0]    found_idx;
  logic               rd_en;
  logic [WADDR_W-1:0] rd_addr;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;
  logic [7:0]         wr_data;
  logic [7:0]         set_word;

  assign start    = (last_q == IDX_W'(SLOTS - 1)) ? '0 : last_q + 1'b1;
  assign start_x  = IDXX'(start);
  assign slot_x   = XW'(slot_q);
  assign last_x   = XW'(last_q);
  assign in_range = 32'(slot_q) < 32'(SLOTS);
  assign issuing  = issue_cnt_q <= CNT_W'(WORDS);

  // Candidate bits of the word under check, in scan order from the start slot.
  always_comb begin
    logic [IDXX-1:0] idx;
    for (int b = 0; b < 8; b++) begin
      idx = {rword_q, 3'(b)};
      free_bits[b] = !rdata_q[b] && (32'(idx) < 32'(SLOTS)) && (idx != IDXX'(last_q))
                     && (!rfirst_q || (3'(b) >= sbit_q))
                     && (!rfinal_q || (3'(b) < sbit_q));
    end
  end

  // Lowest free bit wins.
  always_comb begin
    hit_b = '0;
    for (int b = 7; b >= 0; b--) begin
      if (free_bits[b]) hit_b = 3'(b);
    end
  end

  assign hit       = ctl_i.scan_en && pend_q && (free_bits != 8'd0);
  assign found_idx = {rword_q, hit_b};

  assign stat_o.clr_done = (clr_cnt_q == WADDR_W'(WORDS - 1));
  assign stat_o.hit      = hit;
  assign stat_o.miss     = ctl_i.scan_en && pend_q && rfinal_q && !hit;

  // Read port select.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_ptr_q;
    priority if (ctl_i.rd_slot) begin
      rd_en   = 1'b1;
      rd_addr = slot_x[WADDR_W+2:3];
    end else if (ctl_i.rd_last) begin
      rd_en   = 1'b1;
      rd_addr = last_x[WADDR_W+2:3];
    end else if (ctl_i.scan_en && issuing) begin
      rd_en   = 1'b1;
      rd_addr = scan_ptr_q;
    end
  end

  always_comb begin
    set_word = rdata_q;
    set_word[slot_x[2:0]] = val_q;
  end

  // Write port select: clear sweep, set, or mark the slot just found.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = clr_cnt_q;
    wr_data = '0;
    priority if (ctl_i.clr_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end else if (ctl_i.wr_set && in_range) begin
      wr_en   = 1'b1;
      wr_addr = slot_x[WADDR_W+2:3];
      wr_data = set_word;
    end else if (hit) begin
      wr_en   = 1'b1;
      wr_addr = rword_q;
      wr_data = rdata_q | (8'd1 << hit_b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Capture the item.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_item) begin
      cmd_q  <= cmd_i;
      slot_q <= slot_i;
      val_q  <= used_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      full_q      <= 1'b0;
      clr_cnt_q   <= '0;
      scan_ptr_q  <= '0;
      issue_cnt_q <= '0;
      sbit_q      <= '0;
      pend_q      <= 1'b0;
      rfirst_q    <= 1'b0;
      rfinal_q    <= 1'b0;
      rword_q     <= '0;
    end else begin
      if (ctl_i.clr_en) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (ctl_i.ld_item) begin
        scan_ptr_q  <= start_x[IDXX-1:3];
        sbit_q      <= start_x[2:0];
        issue_cnt_q <= '0;
        full_q      <= 1'b0;
      end
      pend_q <= ctl_i.scan_en && issuing;
      if (ctl_i.scan_en && issuing) begin
        rword_q     <= scan_ptr_q;
        rfirst_q    <= (issue_cnt_q == '0);
        rfinal_q    <= (issue_cnt_q == CNT_W'(WORDS));
        issue_cnt_q <= issue_cnt_q + 1'b1;
        scan_ptr_q  <= (scan_ptr_q == WADDR_W'(WORDS - 1)) ? '0 : scan_ptr_q + 1'b1;
      end
      if (hit) last_q <= found_idx[IDX_W-1:0];
      if (stat_o.miss) full_q <= 1'b1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_res) begin
      unique case (cmd_q)
        CMD_ALLOC: begin
          res_slot_q <= last_x[7:0];
          res_used_q <= full_q ? rdata_q[last_x[2:0]] : 1'b1;
          res_full_q <= full_q;
        end
        CMD_SET: begin
          res_slot_q <= slot_q;
          res_used_q <= in_range && val_q;
          res_full_q <= 1'b0;
        end
        CMD_QUERY: begin
          res_slot_q <= slot_q;
          res_used_q <= in_range && rdata_q[slot_x[2:0]];
          res_full_q <= 1'b0;
        end
        default: begin
          res_slot_q <= slot_q;
          res_used_q <= 1'b0;
          res_full_q <= 1'b0;
        end
      endcase
    end
  end

  assign result_slot_o = res_slot_q;
  assign slot_used_o   = res_used_q;
  assign full_res_o    = res_full_q;

endmodule
